// ===== hdl/lpw_pkg.sv =====
package lpw_pkg;

    // Default coordinate width; the top level hands its own value down.
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 16;

    // Depth of the queue between the classifier and the walker.
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [1:0]            dir_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // Step direction codes of one axis.
    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd3;

    // Request modes.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

endpackage

// ===== hdl/lpw_if.sv =====
interface lpw_cmd_if #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [COORD_BITS-1:0]         x_start;
    logic [COORD_BITS-1:0]         y_start;
    logic [COORD_BITS-1:0]         x_end;
    logic [COORD_BITS-1:0]         y_end;
    logic [lpw_pkg::COLOR_BITS-1:0] pen_color;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, pen_color,
                    input ready);
    modport sink   (input valid, mode, x_start, y_start, x_end, y_end, pen_color,
                    output ready);
endinterface

interface lpw_point_if #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         point_x;
    logic [COORD_BITS-1:0]         point_y;
    logic [lpw_pkg::COLOR_BITS-1:0] point_color;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_color, last_point,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_color, last_point,
                    output ready);
endinterface

interface lpw_job_if #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          is_start;
    logic [COORD_BITS-1:0]         org_x;
    logic [COORD_BITS-1:0]         org_y;
    logic [COORD_BITS-1:0]         span_x;
    logic [COORD_BITS-1:0]         span_y;
    logic [COORD_BITS-1:0]         major_span;
    lpw_pkg::dir_t                 dir_x;
    lpw_pkg::dir_t                 dir_y;
    lpw_pkg::color_t               color;

    modport source (output valid, is_start, org_x, org_y, span_x, span_y, major_span,
                    dir_x, dir_y, color, input ready);
    modport sink   (input valid, is_start, org_x, org_y, span_x, span_y, major_span,
                    dir_x, dir_y, color, output ready);
endinterface

// ===== hdl/line_point_walker_unit.sv =====
// With the queue empty and the output free, an accepted request is written into the
//   queue, and from there its point is loaded into the output register.
// Throughput: one request per cycle unless point.ready stalls the output.
// An advance request with no open line is dropped without a point.
// Reset (rst_n low, asynchronous) empties the queue and output stage and closes any line.
module line_point_walker_unit #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lpw_cmd_if.sink     cmd,
    lpw_point_if.source point
);
    import lpw_pkg::*;

    // Classified requests enter the queue; the walker drains it.
    lpw_job_if #(.COORD_BITS(COORD_BITS)) front_job ();
    lpw_job_if #(.COORD_BITS(COORD_BITS)) back_job ();

    // Front: work out spans, directions and step count of a start request.
    lpw_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .cmd (cmd),
        .job (front_job)
    );

    // Queue: hold classified requests so either side can stall alone.
    lpw_queue #(
        .COORD_BITS(COORD_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_ch (front_job),
        .pop_ch  (back_job)
    );

    // Back: advance the error accumulators, emit one point per request,
    // drop advance requests that find no open line.
    lpw_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (back_job),
        .point (point)
    );

endmodule

// ===== hdl/lpw_front.sv =====
module lpw_front #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    lpw_cmd_if.sink   cmd,
    lpw_job_if.source job
);
    import lpw_pkg::*;

    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    dir_t                  dir_x;
    dir_t                  dir_y;

    // Absolute span and step direction of each axis.
    always_comb
    begin
        if (cmd.x_end > cmd.x_start)
        begin
            span_x = cmd.x_end - cmd.x_start;
            dir_x  = DIR_UP;
        end
        else if (cmd.x_end == cmd.x_start)
        begin
            span_x = '0;
            dir_x  = DIR_NONE;
        end
        else
        begin
            span_x = cmd.x_start - cmd.x_end;
            dir_x  = DIR_DOWN;
        end

        if (cmd.y_end > cmd.y_start)
        begin
            span_y = cmd.y_end - cmd.y_start;
            dir_y  = DIR_UP;
        end
        else if (cmd.y_end == cmd.y_start)
        begin
            span_y = '0;
            dir_y  = DIR_NONE;
        end
        else
        begin
            span_y = cmd.y_start - cmd.y_end;
            dir_y  = DIR_DOWN;
        end
    end

    assign job.valid      = cmd.valid;
    assign cmd.ready      = job.ready;
    assign job.is_start   = (cmd.mode == MODE_START);
    assign job.org_x      = cmd.x_start;
    assign job.org_y      = cmd.y_start;
    assign job.span_x     = span_x;
    assign job.span_y     = span_y;
    assign job.major_span = (span_x > span_y) ? span_x : span_y;
    assign job.dir_x      = dir_x;
    assign job.dir_y      = dir_y;
    assign job.color      = cmd.pen_color;

endmodule

// ===== hdl/lpw_queue.sv =====
module lpw_queue #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lpw_job_if.sink   push_ch,
    lpw_job_if.source pop_ch
);
    import lpw_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                  is_start;
        logic [COORD_BITS-1:0] org_x;
        logic [COORD_BITS-1:0] org_y;
        logic [COORD_BITS-1:0] span_x;
        logic [COORD_BITS-1:0] span_y;
        logic [COORD_BITS-1:0] major_span;
        dir_t                  dir_x;
        dir_t                  dir_y;
        color_t                color;
    } entry_t;

    entry_t                slot_reg [QUEUE_DEPTH];
    entry_t                head;
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  push;
    logic                  pop;

    assign push_ch.ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign push = push_ch.valid && push_ch.ready;
    assign pop  = pop_ch.valid && pop_ch.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{is_start:   push_ch.is_start,
                                      org_x:      push_ch.org_x,
                                      org_y:      push_ch.org_y,
                                      span_x:     push_ch.span_x,
                                      span_y:     push_ch.span_y,
                                      major_span: push_ch.major_span,
                                      dir_x:      push_ch.dir_x,
                                      dir_y:      push_ch.dir_y,
                                      color:      push_ch.color};
        end
    end

    assign head              = slot_reg[rd_ptr_reg];
    assign pop_ch.valid      = (count_reg != '0);
    assign pop_ch.is_start   = head.is_start;
    assign pop_ch.org_x      = head.org_x;
    assign pop_ch.org_y      = head.org_y;
    assign pop_ch.span_x     = head.span_x;
    assign pop_ch.span_y     = head.span_y;
    assign pop_ch.major_span = head.major_span;
    assign pop_ch.dir_x      = head.dir_x;
    assign pop_ch.dir_y      = head.dir_y;
    assign pop_ch.color      = head.color;

endmodule

// ===== hdl/lpw_back.sv =====
module lpw_back #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lpw_job_if.sink     job,
    lpw_point_if.source point
);
    import lpw_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 1;

    // Line state.
    logic [COORD_BITS-1:0] cur_x_reg,  cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,  cur_y_next;
    logic [ERR_BITS-1:0]   err_x_reg,  err_x_next;
    logic [ERR_BITS-1:0]   err_y_reg,  err_y_next;
    logic [COORD_BITS-1:0] span_x_reg, span_y_reg, major_reg;
    dir_t                  dir_x_reg,  dir_y_reg;
    logic [ERR_BITS-1:0]   left_reg,   left_next;
    color_t                color_reg;
    logic                  busy_reg,   busy_next;

    // Output stage.
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] point_x_reg;
    logic [COORD_BITS-1:0] point_y_reg;
    color_t                point_color_reg;
    logic                  last_reg;

    // Working values: a start takes its line from the request.
    logic [COORD_BITS-1:0] base_x, base_y;
    logic [ERR_BITS-1:0]   base_err_x, base_err_y, base_left;
    logic [COORD_BITS-1:0] use_span_x, use_span_y, use_major;
    dir_t                  use_dir_x, use_dir_y;
    color_t                use_color;
    logic [ERR_BITS-1:0]   sum_x, sum_y;
    logic                  step_x, step_y;
    logic                  last_emit;
    logic                  drop;
    logic                  out_free;
    logic                  emit;

    function automatic logic [COORD_BITS-1:0] move_coord(input logic [COORD_BITS-1:0] c,
                                                         input dir_t d);
        logic [COORD_BITS-1:0] r;
        begin
            r = c;
            unique case (d)
                DIR_UP:   r = c + 1'b1;
                DIR_DOWN: r = c - 1'b1;
                default:  r = c;
            endcase
            return r;
        end
    endfunction

    assign drop     = !job.is_start && !busy_reg;
    assign out_free = !out_valid_reg || point.ready;
    assign job.ready = drop || out_free;
    assign emit     = job.valid && !drop && out_free;

    always_comb
    begin
        if (job.is_start)
        begin
            base_x     = job.org_x;
            base_y     = job.org_y;
            base_err_x = '0;
            base_err_y = '0;
            base_left  = {1'b0, job.major_span} + 1'b1;
            use_span_x = job.span_x;
            use_span_y = job.span_y;
            use_major  = job.major_span;
            use_dir_x  = job.dir_x;
            use_dir_y  = job.dir_y;
            use_color  = job.color;
        end
        else
        begin
            base_x     = cur_x_reg;
            base_y     = cur_y_reg;
            base_err_x = err_x_reg;
            base_err_y = err_y_reg;
            base_left  = left_reg;
            use_span_x = span_x_reg;
            use_span_y = span_y_reg;
            use_major  = major_reg;
            use_dir_x  = dir_x_reg;
            use_dir_y  = dir_y_reg;
            use_color  = color_reg;
        end

        left_next  = base_left - 1'b1;
        last_emit  = (left_next == '0);
        busy_next  = !last_emit;

        sum_x  = base_err_x + {1'b0, use_span_x};
        sum_y  = base_err_y + {1'b0, use_span_y};
        step_x = (sum_x > {1'b0, use_major});
        step_y = (sum_y > {1'b0, use_major});

        err_x_next = step_x ? sum_x - {1'b0, use_major} : sum_x;
        err_y_next = step_y ? sum_y - {1'b0, use_major} : sum_y;
        cur_x_next = step_x ? move_coord(base_x, use_dir_x) : base_x;
        cur_y_next = step_y ? move_coord(base_y, use_dir_y) : base_y;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_x_reg     <= '0;
            err_y_reg     <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            major_reg     <= '0;
            dir_x_reg     <= DIR_NONE;
            dir_y_reg     <= DIR_NONE;
            left_reg      <= '0;
            color_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                cur_x_reg  <= cur_x_next;
                cur_y_reg  <= cur_y_next;
                err_x_reg  <= err_x_next;
                err_y_reg  <= err_y_next;
                span_x_reg <= use_span_x;
                span_y_reg <= use_span_y;
                major_reg  <= use_major;
                dir_x_reg  <= use_dir_x;
                dir_y_reg  <= use_dir_y;
                left_reg   <= left_next;
                color_reg  <= use_color;
                busy_reg   <= busy_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            point_x_reg     <= base_x;
            point_y_reg     <= base_y;
            point_color_reg <= use_color;
            last_reg        <= last_emit;
        end
    end

    assign point.valid       = out_valid_reg;
    assign point.point_x     = point_x_reg;
    assign point.point_y     = point_y_reg;
    assign point.point_color = point_color_reg;
    assign point.last_point  = last_reg;

    a_last_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_emit) |=> !busy_reg)
        else $error("line still open after its last point");

    a_inner_keeps_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last_emit) |=> (busy_reg && left_reg != '0))
        else $error("line closed before its last point");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (err_x_reg <= {1'b0, major_reg}) && (err_y_reg <= {1'b0, major_reg}))
        else $error("error accumulator above step count");

    a_span_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (span_x_reg <= major_reg) && (span_y_reg <= major_reg))
        else $error("axis span above step count");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import lpw_pkg::*;

    localparam int CB             = 12;     // coordinate width under test
    localparam int EB             = CB + 1; // width of the error accumulators
    localparam int COORD_MAX      = (1 << CB) - 1;
    localparam int QUIET_LIMIT    = 4000;   // cycles with no handshake on either side
    localparam int HOLDOFF_CYCLES = 400;
    localparam int REPORT_MAX     = 10;

    // One request as the sender sees it, and one point as the receiver sees it.
    typedef struct {
        logic          mode;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        color_t        color;
    } draw_req_t;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        color_t        color;
        logic          is_last;
    } pixel_t;

    logic clk;
    logic rst_n;

    lpw_cmd_if   #(.COORD_BITS(CB)) cmd_bus ();
    lpw_point_if #(.COORD_BITS(CB)) point_bus ();

    line_point_walker_unit #(.COORD_BITS(CB)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .point (point_bus)
    );

    // Points still owed by the block, oldest first.
    pixel_t expected_pixels[$];

    int fail_count   = 0;
    int points_due   = 0;   // points predicted so far
    int sent_reqs    = 0;
    int burst_left   = 0;   // requests left in the current sender burst
    int stall_left   = 0;   // receiver hold-off, counted down by the receiver
    int quiet_cycles = 0;

    // Walker state as predicted from the accepted requests.
    logic [CB-1:0] pen_x, pen_y;
    logic [EB-1:0] acc_x, acc_y;
    logic [CB-1:0] run_x, run_y, run_major;
    dir_t          step_x, step_y;
    logic [EB-1:0] pts_to_go;
    color_t        ink;
    bit            line_open;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Failure bookkeeping: print the first few, count the rest
    // ------------------------------------------------------------------
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Point predictor
    // ------------------------------------------------------------------
    function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] c, input dir_t d);
        if (d == DIR_UP)
            return c + 1'b1;
        if (d == DIR_DOWN)
            return c - 1'b1;
        return c;
    endfunction

    // Advance the predicted walker by one accepted request. Return 1 and the
    // point when the request yields one; an advance with no open line is dropped.
    function automatic bit predict_pixel(input draw_req_t r, output pixel_t px);
        px = '{default: '0};
        if (r.mode == MODE_ADVANCE && !line_open)
            return 1'b0;

        if (r.mode == MODE_START)
        begin
            // Latch spans and directions per axis; the longer span sets the count.
            if (r.xe > r.xs)
            begin
                run_x  = r.xe - r.xs;
                step_x = DIR_UP;
            end
            else if (r.xe == r.xs)
            begin
                run_x  = '0;
                step_x = DIR_NONE;
            end
            else
            begin
                run_x  = r.xs - r.xe;
                step_x = DIR_DOWN;
            end
            if (r.ye > r.ys)
            begin
                run_y  = r.ye - r.ys;
                step_y = DIR_UP;
            end
            else if (r.ye == r.ys)
            begin
                run_y  = '0;
                step_y = DIR_NONE;
            end
            else
            begin
                run_y  = r.ys - r.ye;
                step_y = DIR_DOWN;
            end
            run_major = (run_x > run_y) ? run_x : run_y;
            pen_x     = r.xs;
            pen_y     = r.ys;
            acc_x     = '0;
            acc_y     = '0;
            pts_to_go = {1'b0, run_major} + 1'b1;
            ink       = r.color;
            line_open = 1'b1;
        end

        // Emit the current point, then step the accumulators.
        pts_to_go  = pts_to_go - 1'b1;
        px.x       = pen_x;
        px.y       = pen_y;
        px.color   = ink;
        px.is_last = (pts_to_go == '0);
        line_open  = !px.is_last;

        acc_x = acc_x + {1'b0, run_x};
        acc_y = acc_y + {1'b0, run_y};
        if (acc_x > {1'b0, run_major})
        begin
            acc_x = acc_x - {1'b0, run_major};
            pen_x = step_coord(pen_x, step_x);
        end
        if (acc_y > {1'b0, run_major})
        begin
            acc_y = acc_y - {1'b0, run_major};
            pen_y = step_coord(pen_y, step_y);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic draw_req_t make_line(input int xs, input int ys, input int xe,
                                            input int ye, input int color);
        draw_req_t r;
        r.mode  = MODE_START;
        r.xs    = xs[CB-1:0];
        r.ys    = ys[CB-1:0];
        r.xe    = xe[CB-1:0];
        r.ye    = ye[CB-1:0];
        r.color = color[COLOR_BITS-1:0];
        return r;
    endfunction

    // Advance requests carry random payload; the block must ignore it.
    function automatic draw_req_t advance_req();
        draw_req_t r;
        r      = make_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, 65535));
        r.mode = MODE_ADVANCE;
        return r;
    endfunction

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Line from a random origin to a nearby endpoint, at most reach away per axis.
    function automatic draw_req_t short_line(input int reach);
        int xs, ys;
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        return make_line(xs, ys,
                         clip_coord(xs + int'($urandom_range(0, 2 * reach)) - reach),
                         clip_coord(ys + int'($urandom_range(0, 2 * reach)) - reach),
                         $urandom_range(0, 65535));
    endfunction

    // Number of advances that finish a line after its start request.
    function automatic int line_steps(input draw_req_t r);
        int dx, dy;
        dx = (r.xe > r.xs) ? int'(r.xe - r.xs) : int'(r.xs - r.xe);
        dy = (r.ye > r.ys) ? int'(r.ye - r.ys) : int'(r.ys - r.ye);
        return (dx > dy) ? dx : dy;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Requests go out
    // in bursts; between bursts drop valid for a random gap, which may be zero.
    task automatic send_req(input draw_req_t r);
        pixel_t px;
        int     gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            // Now and then run a long burst with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;

        @(negedge clk);
        cmd_bus.valid     <= 1'b1;
        cmd_bus.mode      <= r.mode;
        cmd_bus.x_start   <= r.xs;
        cmd_bus.y_start   <= r.ys;
        cmd_bus.x_end     <= r.xe;
        cmd_bus.y_end     <= r.ye;
        cmd_bus.pen_color <= r.color;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);

        sent_reqs++;
        if (predict_pixel(r, px))
        begin
            expected_pixels.push_back(px);
            points_due++;
        end
    endtask

    // Start a line and follow it with the given number of advances.
    task automatic walk_line(input draw_req_t r, input int advances);
        send_req(r);
        repeat (advances) send_req(advance_req());
    endtask

    // Stop offering and wait for every owed point to come out.
    task automatic wait_drain();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that is redrawn periodically;
    // a pending hold-off overrides it.
    // ------------------------------------------------------------------
    initial
    begin
        int rx_cycle;
        int rx_pattern;
        rx_cycle        = 0;
        rx_pattern      = 0;
        point_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 300 == 0)
                rx_pattern = $urandom_range(0, 3);
            if (stall_left > 0)
            begin
                stall_left--;
                point_bus.ready <= 1'b0;
            end
            else
            begin
                case (rx_pattern)
                    0:       point_bus.ready <= 1'b1;
                    1:       point_bus.ready <= ($urandom_range(0, 9) < 7);
                    2:       point_bus.ready <= ((rx_cycle % 5) < 3);
                    default: point_bus.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Point checker: compare each accepted point with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && point_bus.valid === 1'b1 && point_bus.ready === 1'b1)
        begin
            got.x       = point_bus.point_x;
            got.y       = point_bus.point_y;
            got.color   = point_bus.point_color;
            got.is_last = point_bus.last_point;
            if (expected_pixels.size() == 0)
                note_failure($sformatf("unexpected point x=%0d y=%0d color=%h last=%b",
                                       got.x, got.y, got.color, got.is_last));
            else
            begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                    got.is_last !== want.is_last)
                    note_failure($sformatf(
                        "point mismatch: exp x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                        want.x, want.y, want.color, want.is_last,
                        got.x, got.y, got.color, got.is_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either side for too long
    // ------------------------------------------------------------------
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (point_bus.valid === 1'b1 && point_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request or point moved for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked lines: idle advances, single points, extremes, restarts.
    task automatic test_directed();
        // advance with no open line: dropped
        send_req(advance_req());
        // single point at the origin, then an advance past its end
        walk_line(make_line(0, 0, 0, 0, 16'h0000), 0);
        send_req(advance_req());
        // single point at the far corner, full-scale color
        walk_line(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF), 0);
        // shallow line walked to its end, then one advance too many
        walk_line(make_line(0, 0, 5, 2, 16'h1234), 5);
        send_req(advance_req());
        // steep line running left, abandoned after a few points
        walk_line(make_line(COORD_MAX, 0, COORD_MAX - 3, COORD_MAX, 16'hA5A5), 3);
        // restart: x rising and y falling, walked to the end
        walk_line(make_line(10, 20, 12, 14, 16'hF800), 6);
        // full diagonal across the field, abandoned early
        walk_line(make_line(0, COORD_MAX, COORD_MAX, 0, 16'h07E0), 2);
    endtask

    // Mostly well-formed lines with random content, plus abandoned lines,
    // surplus advances and stray advances.
    task automatic test_random_lines(input int point_target);
        draw_req_t r;
        int        first, kind, n, v;
        bit        start_line;
        first = points_due;
        while (points_due - first < point_target)
        begin
            kind       = $urandom_range(0, 99);
            start_line = 1'b1;
            if (kind < 65)
            begin
                r = short_line(($urandom_range(0, 9) == 0) ? 63 : 15);
                n = line_steps(r);
            end
            else if (kind < 80)
            begin
                // endpoints anywhere in the field; walk a few points and move on
                r = make_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, 65535));
                n = $urandom_range(0, 40);
            end
            else if (kind < 84)
            begin
                r = short_line(255);
                n = line_steps(r);
            end
            else if (kind < 92)
            begin
                // stray advances: continue whatever is open, or get dropped
                repeat ($urandom_range(1, 3)) send_req(advance_req());
                start_line = 1'b0;
            end
            else
            begin
                // axis-aligned or single-point line
                r = short_line(15);
                if ($urandom_range(0, 1))
                    r.xe = r.xs;
                else
                    r.ye = r.ys;
                n = line_steps(r);
            end

            if (start_line)
            begin
                v = $urandom_range(0, 9);
                if (v == 0)
                    n = $urandom_range(0, n);       // abandon by the next start
                else if (v == 1)
                    n = n + $urandom_range(1, 3);   // advances past the last point
                walk_line(r, n);
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering back to back, so
    // the block fills and stalls its input.
    task automatic test_holdoff();
        draw_req_t r;
        stall_left = HOLDOFF_CYCLES;
        burst_left = 1000000;
        repeat (4)
        begin
            r = short_line(15);
            walk_line(r, line_steps(r) + 1);
        end
        burst_left = 0;
    endtask

    // Finish a line, let the block run dry, pause, and go again.
    task automatic test_drain_pause();
        draw_req_t r;
        repeat (6)
        begin
            r = short_line(15);
            walk_line(r, line_steps(r));
            wait_drain();
            repeat ($urandom_range(5, 40)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before reset lets go.
        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.mode      = MODE_START;
        cmd_bus.x_start   = '0;
        cmd_bus.y_start   = '0;
        cmd_bus.x_end     = '0;
        cmd_bus.y_end     = '0;
        cmd_bus.pen_color = '0;
        line_open         = 1'b0;
        pen_x             = '0;
        pen_y             = '0;
        acc_x             = '0;
        acc_y             = '0;
        run_x             = '0;
        run_y             = '0;
        run_major         = '0;
        step_x            = DIR_NONE;
        step_y            = DIR_NONE;
        pts_to_go         = '0;
        ink               = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_holdoff();
        test_random_lines(600);
        test_drain_pause();
        test_random_lines(650);
        test_holdoff();

        // Let the last points out, then keep the clock running so that the
        // block can show anything it should not.
        wait_drain();
        repeat (20) @(posedge clk);

        if (expected_pixels.size() != 0)
            note_failure($sformatf("%0d expected points never arrived",
                                   expected_pixels.size()));
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
